// ----- design/pcxrle_pkg.sv -----
`default_nettype none
package pcxrle_pkg;

   localparam int unsigned PIXEL_W      = 8;
   localparam int unsigned RUN_LEN_W    = 6;
   localparam int unsigned COLUMN_W     = 16;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam logic [RUN_LEN_W-1:0] RUN_MAX    = 6'h3F;
   localparam logic [PIXEL_W-1:0]   SINGLE_MAX = 8'hBF;
   localparam logic [PIXEL_W-1:0]   COUNT_MARK = 8'hC0;

   localparam logic [COLUMN_W-1:0] LINE_WIDTH_RESET  = 16'd1;
   localparam logic [PIXEL_W-1:0]  TRANSPARENT_RESET = 8'd0;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPARENT = 2'd1;

   // One closed run, ready to be expanded into bytes
   typedef struct packed {
      logic                 valid;
      logic [PIXEL_W-1:0]   value;
      logic [RUN_LEN_W-1:0] length;
   } run_type;

   // Work handed from front to back for one pixel: old run, then new run
   typedef struct packed {
      run_type a;
      run_type b;
      logic    line_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // A run needs a count byte unless it is a single low-valued pixel
   function automatic logic needs_count(input run_type r);
      needs_count = r.valid && ((r.length != RUN_LEN_W'(1)) || (r.value > SINGLE_MAX));
   endfunction

endpackage
`default_nettype wire

// ----- design/pcxrle_front.sv -----
`default_nettype none
module pcxrle_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [pcxrle_pkg::PIXEL_W-1:0]         req_pixel_index,
   input  wire logic                                   req_is_transparent,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [pcxrle_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pcxrle_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire pcxrle_pkg::q_status_type               q_status,
   output logic                                        q_push,
   output pcxrle_pkg::cmd_type                         q_cmd
);

   localparam int unsigned PW = pcxrle_pkg::PIXEL_W;
   localparam int unsigned LW = pcxrle_pkg::RUN_LEN_W;
   localparam int unsigned CW = pcxrle_pkg::COLUMN_W;

   logic [CW-1:0] line_width_ff, line_width_in;
   logic [PW-1:0] trans_index_ff, trans_index_in;
   logic [PW-1:0] run_value_ff, run_value_in;
   logic [LW-1:0] run_len_ff, run_len_in;
   logic [CW-1:0] column_ff, column_in;

   logic          accept;
   logic [PW-1:0] pix;
   logic          flush_a;
   logic          extend;
   logic [LW-1:0] len_new;
   logic [PW-1:0] val_new;
   logic [CW:0]   col_inc;
   logic          line_done;
   logic          flush_b;

   assign req_ready = !q_status.full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pix       = req_is_transparent ? trans_index_ff : req_pixel_index;
      flush_a   = (run_len_ff != '0) && (pix != run_value_ff);
      extend    = (run_len_ff != '0) && !flush_a;
      len_new   = extend ? (run_len_ff + LW'(1)) : LW'(1);
      val_new   = extend ? run_value_ff : pix;
      col_inc   = {1'b0, column_ff} + (CW+1)'(1);
      // Zero width compares like one: every pixel ends the line
      line_done = col_inc >= {1'b0, line_width_ff};
      flush_b   = (len_new == pcxrle_pkg::RUN_MAX) || line_done;
   end

   always_comb begin
      q_cmd.a.valid  = flush_a;
      q_cmd.a.value  = run_value_ff;
      q_cmd.a.length = run_len_ff;
      q_cmd.b.valid  = flush_b;
      q_cmd.b.value  = val_new;
      q_cmd.b.length = len_new;
      q_cmd.line_end = line_done;
      // A pixel that only extends a run sends nothing
      q_push         = accept && (flush_a || flush_b);
   end

   always_comb begin
      run_value_in = run_value_ff;
      run_len_in   = run_len_ff;
      column_in    = column_ff;
      if (accept) begin
         run_value_in = val_new;
         run_len_in   = flush_b ? '0 : len_new;
         column_in    = line_done ? '0 : col_inc[CW-1:0];
      end
   end

   always_comb begin
      line_width_in  = line_width_ff;
      trans_index_in = trans_index_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pcxrle_pkg::CSR_LINE_WIDTH:  line_width_in  = csr_wdata;
            pcxrle_pkg::CSR_TRANSPARENT: trans_index_in = csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= pcxrle_pkg::LINE_WIDTH_RESET;
         trans_index_ff <= pcxrle_pkg::TRANSPARENT_RESET;
         run_value_ff   <= '0;
         run_len_ff     <= '0;
         column_ff      <= '0;
      end else begin
         line_width_ff  <= line_width_in;
         trans_index_ff <= trans_index_in;
         run_value_ff   <= run_value_in;
         run_len_ff     <= run_len_in;
         column_ff      <= column_in;
      end
   end

   a_line_flushes: assert property (@(posedge clock) disable iff (reset)
      accept && line_done |-> q_push && q_cmd.b.valid && (run_len_in == '0))
      else $error("line end did not close the open run");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_len_ff != pcxrle_pkg::RUN_MAX)
      else $error("run left open at maximum length");

endmodule
`default_nettype wire

// ----- design/pcxrle_queue.sv -----
`default_nettype none
module pcxrle_queue #(
   parameter int unsigned DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire pcxrle_pkg::cmd_type      push_cmd,
   input  wire logic                     pop,
   output pcxrle_pkg::cmd_type           head_cmd,
   output pcxrle_pkg::q_status_type      status
);

   localparam int unsigned PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0]   PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CountW-1:0] CountFull = CountW'(DEPTH);

   pcxrle_pkg::cmd_type entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CountFull);
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : (wr_ptr_ff + PtrW'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : (rd_ptr_ff + PtrW'(1));
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("transfer into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CountW'(1))
      else $error("queue count lost a transfer");

endmodule
`default_nettype wire

// ----- design/pcxrle_back.sv -----
`default_nettype none
module pcxrle_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire pcxrle_pkg::cmd_type              head_cmd,
   input  wire pcxrle_pkg::q_status_type         q_status,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [pcxrle_pkg::PIXEL_W-1:0]        rsp_code_byte,
   output logic                                  rsp_last_of_item,
   output logic                                  rsp_line_end
);

   localparam int unsigned PW = pcxrle_pkg::PIXEL_W;

   // Byte slots of one command, in send order: a count, a value, b count, b value
   logic [3:0]    need;
   logic [3:0]    rem;
   logic [3:0]    sel;
   logic [3:0]    done_ff, done_in;
   logic          last;
   logic          emit;
   logic          out_free;
   logic [PW-1:0] byte_sel;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] code_ff, code_in;
   logic          last_ff, last_in;
   logic          line_end_ff, line_end_in;

   always_comb begin
      need[0] = pcxrle_pkg::needs_count(head_cmd.a);
      need[1] = head_cmd.a.valid;
      need[2] = pcxrle_pkg::needs_count(head_cmd.b);
      need[3] = head_cmd.b.valid;
      rem     = need & ~done_ff;
      sel     = rem & (~rem + 4'd1);
      last    = (rem & ~sel) == 4'd0;
      if (sel[0]) begin
         byte_sel = pcxrle_pkg::COUNT_MARK | PW'(head_cmd.a.length);
      end else if (sel[1]) begin
         byte_sel = head_cmd.a.value;
      end else if (sel[2]) begin
         byte_sel = pcxrle_pkg::COUNT_MARK | PW'(head_cmd.b.length);
      end else begin
         byte_sel = head_cmd.b.value;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = !q_status.empty && out_free;
   assign q_pop    = emit && last;

   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      code_in      = code_ff;
      last_in      = last_ff;
      line_end_in  = line_end_ff;
      if (emit) begin
         done_in      = last ? 4'd0 : (done_ff | sel);
         rsp_valid_in = 1'b1;
         code_in      = byte_sel;
         last_in      = last;
         // The closing run's value byte is always the command's final byte
         line_end_in  = last && head_cmd.line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      last_ff     <= last_in;
      line_end_ff <= line_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_byte    = code_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_line_end     = line_end_ff;

   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_last_of_item)
      else $error("line end on a byte that is not last of its pixel");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid && (rsp_code_byte == $past(byte_sel)))
      else $error("emitted byte not presented");

   a_head_has_bytes: assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> rem != 4'd0)
      else $error("queued command with nothing left to send");

endmodule
`default_nettype wire

// ----- design/pcx_rle_line_encoder_core.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_pixel_index[7:0], req_is_transparent
// rsp       out        rsp_valid/rsp_ready    rsp_code_byte[7:0], rsp_last_of_item, rsp_line_end
// csr       in         csr_valid/csr_ready    csr_index[1:0], csr_wdata[15:0]
//
// The front end takes one pixel per cycle while the command queue is not full, and
// queues the runs it closes; the back end sends one byte per cycle from its output
// register while a command waits and the output is not stalled by rsp_ready;
// a pixel causes up to 4 bytes.
// Output byte appears in the cycle after the back end picks it from the queue head.
// Synchronous reset clears run state, queue and output valid; no clearing pass.
// req_ready drops only while the command queue is full; csr_ready is always high.
`default_nettype none
module pcx_rle_line_encoder_core #(
   parameter int unsigned QUEUE_DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [pcxrle_pkg::PIXEL_W-1:0]      req_pixel_index,
   input  wire logic                                req_is_transparent,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [pcxrle_pkg::PIXEL_W-1:0]           rsp_code_byte,
   output logic                                     rsp_last_of_item,
   output logic                                     rsp_line_end,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pcxrle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pcxrle_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   pcxrle_pkg::q_status_type q_status;
   pcxrle_pkg::cmd_type      push_cmd;
   pcxrle_pkg::cmd_type      head_cmd;
   logic                     q_push;
   logic                     q_pop;

   pcxrle_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_index    (req_pixel_index),
      .req_is_transparent (req_is_transparent),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_cmd              (push_cmd)
   );

   pcxrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   pcxrle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_line_end     (rsp_line_end)
   );

endmodule
`default_nettype wire
